/* rtl/chip8_subset_instruction_executor_defines.svh */
// ============================================================================
// chip8 subset executor assertion macros
// shared concurrent assertion forms, clocked on i_clk, disabled in reset
// ============================================================================
`ifndef CHIP8_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define CHIP8_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define C8E_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C8E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/c8e_pkg.sv */
// ============================================================================
// c8e_pkg
// shared widths, codes and memory request types of the chip8 subset executor
// ============================================================================
`default_nettype none

package c8e_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int SCREEN_COLS = 64;
    localparam int SCREEN_ROWS = 32;
    localparam int NUM_VREGS   = 16;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int VREG_W = $clog2(NUM_VREGS);

    localparam logic [ADDR_W-1:0] PC_START = 12'h200;

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    // opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS = 4'h0;
    localparam logic [3:0] OPG_JP  = 4'h1;
    localparam logic [3:0] OPG_SE  = 4'h3;
    localparam logic [3:0] OPG_LDV = 4'h6;
    localparam logic [3:0] OPG_ADD = 4'h7;
    localparam logic [3:0] OPG_LDI = 4'hA;
    localparam logic [3:0] OPG_DRW = 4'hD;

    localparam logic [15:0] OP_CLS = 16'h00E0;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_pm_req;

    typedef struct packed {
        logic                   clr;
        logic                   we;
        logic [ROW_W-1:0]       addr;
        logic [SCREEN_COLS-1:0] wdata;
    } t_fb_req;

    typedef struct packed {
        logic              we;
        logic [VREG_W-1:0] addr;
        logic [7:0]        wdata;
    } t_vr_req;

endpackage

`default_nettype wire

/* rtl/c8e_if.sv */
// ============================================================================
// c8e channel interfaces
// valid/ready channels carrying the input item and the result item
// ============================================================================
`default_nettype none

interface c8e_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [c8e_pkg::ADDR_W-1:0] address;
    logic [7:0]                data;

    modport source (output valid, output mode, output address, output data, input ready);
    modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

interface c8e_out_if;
    logic                           valid;
    logic                           ready;
    logic [c8e_pkg::ADDR_W-1:0]     program_counter;
    logic [15:0]                    opcode_run;
    logic [c8e_pkg::ADDR_W-1:0]     index_value;
    logic                           status;
    logic [c8e_pkg::SCREEN_COLS-1:0] screen_row;

    modport source (output valid, output program_counter, output opcode_run,
                    output index_value, output status, output screen_row, input ready);
    modport sink   (input valid, input program_counter, input opcode_run,
                    input index_value, input status, input screen_row, output ready);
endinterface

`default_nettype wire

/* rtl/c8e_pmem.sv */
// ============================================================================
// c8e_pmem
// 4 KiB program memory, one port, registered read, zero sweep after reset
// ============================================================================
`default_nettype none

module c8e_pmem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire c8e_pkg::t_pm_req           i_req,
    output logic [7:0]                      o_rdata,
    output logic                            o_busy
);

    logic [7:0]                 r_mem [0:c8e_pkg::MEM_BYTES-1];
    logic [7:0]                 r_rdata;
    logic [c8e_pkg::ADDR_W-1:0] r_clr_addr;
    logic                       r_busy;
    logic [c8e_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       wr_en;

    always_comb begin
        wr_en   = r_busy | i_req.we;
        wr_addr = r_busy ? r_clr_addr : i_req.addr;
        wr_data = r_busy ? 8'h00 : i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

/* rtl/c8e_fbuf.sv */
// ============================================================================
// c8e_fbuf
// 32 x 64 frame buffer memory, per-row valid bits let a clear blank every row
// ============================================================================
`default_nettype none

module c8e_fbuf (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire c8e_pkg::t_fb_req                  i_req,
    output logic [c8e_pkg::SCREEN_COLS-1:0]        o_rdata
);

    logic [c8e_pkg::SCREEN_COLS-1:0] r_mem [0:c8e_pkg::SCREEN_ROWS-1];
    logic [c8e_pkg::SCREEN_ROWS-1:0] r_vld;
    logic [c8e_pkg::SCREEN_COLS-1:0] r_rdata;
    logic                            r_rvld;

    // a row never written since reset or the last clear reads as blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_req.addr];
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.we) begin
                r_vld[i_req.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

/* rtl/c8e_vreg.sv */
// ============================================================================
// c8e_vreg
// sixteen 8-bit general registers in a small memory with valid bits
// ============================================================================
`default_nettype none

module c8e_vreg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire c8e_pkg::t_vr_req  i_req,
    output logic [7:0]             o_rdata
);

    logic [7:0]                     r_mem [0:c8e_pkg::NUM_VREGS-1];
    logic [c8e_pkg::NUM_VREGS-1:0]  r_vld;
    logic [7:0]                     r_rdata;
    logic                           r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_req.addr];
            if (i_req.we) begin
                r_vld[i_req.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rvld ? r_rdata : 8'h00;

endmodule

`default_nettype wire

/* rtl/chip8_subset_instruction_executor.sv */
// ============================================================================
// chip8_subset_instruction_executor
// reduced chip8 core: program load, single-opcode execute, screen row read
// ============================================================================
// usage:
//   i_in carries one item (mode, address, data); o_out returns exactly one
//   result item per input item, in order.
//   mode load writes the byte, mode read reads and captures a screen row,
//   mode execute fetches both opcode bytes, decodes and executes; draw adds
//   a vy read and then, per sprite row (N rows), a memory read state and a
//   frame-buffer write-back state. one item is worked on at a time: the
//   next item can be taken in the cycle after the result is registered.
//   after reset the program memory is swept to zero, one byte a cycle,
//   so i_in.ready stays low until the sweep ends; registers, index and screen
//   clear at once and pc starts at 0x200.
//   the result sits in an output register: while the receiver stalls the
//   block still takes the next item and works it, then holds that result
//   until the output register frees up.
// ============================================================================
`default_nettype none

module chip8_subset_instruction_executor (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    c8e_in_if.sink     i_in,
    c8e_out_if.source  o_out
);

    localparam int ADDR_W = c8e_pkg::ADDR_W;
    localparam int ROW_W  = c8e_pkg::ROW_W;
    localparam int COL_W  = c8e_pkg::COL_W;
    localparam int COLS   = c8e_pkg::SCREEN_COLS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_FETCH_HI = 4'd2;
    localparam logic [3:0] S_FETCH_LO = 4'd3;
    localparam logic [3:0] S_DECODE   = 4'd4;
    localparam logic [3:0] S_EXEC     = 4'd5;
    localparam logic [3:0] S_DRW_Y    = 4'd6;
    localparam logic [3:0] S_DRW_RD   = 4'd7;
    localparam logic [3:0] S_DRW_WR   = 4'd8;
    localparam logic [3:0] S_ROW_RD   = 4'd9;
    localparam logic [3:0] S_ROW_CAP  = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    // place an 8-pixel sprite row at column x, wrapping at the right edge
    function automatic logic [COLS-1:0] sprite_row(input logic [7:0] bits,
                                                   input logic [COL_W-1:0] x);
        logic [2*COLS-1:0] w;
        w = {bits, {(COLS-8){1'b0}}, bits, {(COLS-8){1'b0}}} >> x;
        return w[COLS-1:0];
    endfunction

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] n_pc;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;
    logic              r_o_valid;

    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_data;
    logic [7:0]        r_hi;
    logic [15:0]       r_op;
    logic              r_st;
    logic              n_st;
    logic [COLS-1:0]   r_scr;
    logic [COL_W-1:0]  r_vx;
    logic [ROW_W-1:0]  r_vy;
    logic [3:0]        r_row;

    logic [ADDR_W-1:0] r_o_pc;
    logic [15:0]       r_o_op;
    logic [ADDR_W-1:0] r_o_idx;
    logic              r_o_st;
    logic [COLS-1:0]   r_o_scr;

    c8e_pkg::t_pm_req  pm_req;
    c8e_pkg::t_fb_req  fb_req;
    c8e_pkg::t_vr_req  vr_req;
    logic [7:0]        pm_rdata;
    logic              pm_busy;
    logic [COLS-1:0]   fb_rdata;
    logic [7:0]        vr_rdata;

    logic              in_take;
    logic              out_free;
    logic [ROW_W-1:0]  drw_row;
    logic [7:0]        nn;

    assign in_take  = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;
    assign drw_row  = r_vy + {1'b0, r_row};
    assign nn       = r_op[7:0];

    assign i_in.ready = (r_state == S_IDLE) && !pm_busy;

    c8e_pmem u_pmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pm_req),
        .o_rdata (pm_rdata),
        .o_busy  (pm_busy)
    );

    c8e_fbuf u_fbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fb_req),
        .o_rdata (fb_rdata)
    );

    c8e_vreg u_vreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vr_req),
        .o_rdata (vr_rdata)
    );

    // memory requests and next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_idx   = r_idx;
        n_st    = r_st;
        pm_req  = '{we: 1'b0, addr: r_pc, wdata: r_data};
        fb_req  = '{clr: 1'b0, we: 1'b0, addr: drw_row, wdata: '0};
        vr_req  = '{we: 1'b0, addr: r_op[11:8], wdata: nn};

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_st = 1'b0;
                    unique case (i_in.mode)
                        c8e_pkg::MODE_LOAD: n_state = S_LOAD;
                        c8e_pkg::MODE_EXEC: n_state = S_FETCH_HI;
                        c8e_pkg::MODE_READ: n_state = S_ROW_RD;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                pm_req.we   = 1'b1;
                pm_req.addr = r_addr;
                n_pc        = c8e_pkg::PC_START;
                n_state     = S_DONE;
            end
            S_FETCH_HI: begin
                pm_req.addr = r_pc;
                n_state     = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                pm_req.addr = r_pc + 1'b1;
                n_state     = S_DECODE;
            end
            S_DECODE: begin
                vr_req.addr = r_hi[3:0];
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                n_pc    = r_pc + 12'd2;
                n_state = S_DONE;
                unique case (r_op[15:12])
                    c8e_pkg::OPG_SYS: begin
                        if (r_op == c8e_pkg::OP_CLS) begin
                            fb_req.clr = 1'b1;
                        end else begin
                            n_st = 1'b1;
                        end
                    end
                    c8e_pkg::OPG_JP: begin
                        n_pc = r_op[11:0];
                    end
                    c8e_pkg::OPG_SE: begin
                        if (vr_rdata == nn) begin
                            n_pc = r_pc + 12'd4;
                        end
                    end
                    c8e_pkg::OPG_LDV: begin
                        vr_req.we = 1'b1;
                    end
                    c8e_pkg::OPG_ADD: begin
                        vr_req.we    = 1'b1;
                        vr_req.wdata = vr_rdata + nn;
                    end
                    c8e_pkg::OPG_LDI: begin
                        n_idx = r_op[11:0];
                    end
                    c8e_pkg::OPG_DRW: begin
                        vr_req.addr = r_op[7:4];
                        n_state     = S_DRW_Y;
                    end
                    default: begin
                        n_st = 1'b1;
                    end
                endcase
            end
            S_DRW_Y: begin
                n_state = (r_op[3:0] == 4'd0) ? S_DONE : S_DRW_RD;
            end
            S_DRW_RD: begin
                pm_req.addr = r_idx + {{(ADDR_W-4){1'b0}}, r_row};
                n_state     = S_DRW_WR;
            end
            S_DRW_WR: begin
                // rows of one sprite land on distinct screen rows, so the
                // read of the next row never meets this write
                fb_req.we    = 1'b1;
                fb_req.wdata = fb_rdata ^ sprite_row(pm_rdata, r_vx);
                n_state      = (r_row == r_op[3:0] - 4'd1) ? S_DONE : S_DRW_RD;
            end
            S_ROW_RD: begin
                fb_req.addr = r_addr[ROW_W-1:0];
                n_state     = S_ROW_CAP;
            end
            S_ROW_CAP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= c8e_pkg::PC_START;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_idx   <= n_idx;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (in_take) begin
            r_mode <= i_in.mode;
            r_addr <= i_in.address;
            r_data <= i_in.data;
            r_op   <= '0;
            r_scr  <= '0;
        end
        if (r_state == S_FETCH_LO) begin
            r_hi <= pm_rdata;
        end
        if (r_state == S_DECODE) begin
            r_op <= {r_hi, pm_rdata};
        end
        if (r_state == S_EXEC) begin
            r_vx <= vr_rdata[COL_W-1:0];
        end
        if (r_state == S_DRW_Y) begin
            r_vy  <= vr_rdata[ROW_W-1:0];
            r_row <= '0;
        end
        if (r_state == S_DRW_WR) begin
            r_row <= r_row + 4'd1;
        end
        if (r_state == S_ROW_CAP && r_mode == c8e_pkg::MODE_READ) begin
            r_scr <= fb_rdata;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_pc  <= r_pc;
            r_o_op  <= r_op;
            r_o_idx <= r_idx;
            r_o_st  <= r_st;
            r_o_scr <= r_scr;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.program_counter = r_o_pc;
    assign o_out.opcode_run      = r_o_op;
    assign o_out.index_value     = r_o_idx;
    assign o_out.status          = r_o_st;
    assign o_out.screen_row      = r_o_scr;

endmodule

`default_nettype wire

/* rtl/c8e_checker.sv */
// ============================================================================
// c8e_checker
// port-level checks on the chip8 subset executor, bound to the top level
// ============================================================================
`default_nettype none

`include "chip8_subset_instruction_executor_defines.svh"

module c8e_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [c8e_pkg::ADDR_W-1:0]        i_out_pc,
    input wire logic [15:0]                       i_out_op,
    input wire logic                              i_out_st,
    input wire logic [c8e_pkg::SCREEN_COLS-1:0]   i_out_scr
);

    // memory sweep keeps the input closed right after reset
    `C8E_ASSERT_IMPL(a_closed_after_reset, $past(!i_rst_n), !i_in_ready, "input open during memory sweep")

    // one item in flight: an accepted item closes the input
    `C8E_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready, "second item taken while busy")

    // a screen row only comes from a read item, which carries no opcode
    `C8E_ASSERT_IMPL(a_row_only_on_read, i_out_valid && (i_out_scr != '0), (i_out_op == 16'h0000) && !i_out_st, "screen row on a non-read result")

    // a stalled result holds
    `C8E_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pc) && $stable(i_out_op), "stalled result changed")

endmodule

bind chip8_subset_instruction_executor c8e_checker u_c8e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pc    (o_out.program_counter),
    .i_out_op    (o_out.opcode_run),
    .i_out_st    (o_out.status),
    .i_out_scr   (o_out.screen_row)
);

`default_nettype wire

/* tb/chip8_subset_instruction_executor_tb.sv */
// ============================================================================
// chip8_subset_instruction_executor_tb
// Self-checking bench for the reduced chip8 core. A scoreboard class keeps its
// own copy of memory, registers, index, pc and screen, and predicts one result
// per accepted item. Results are checked in order. The run starts with a
// short directed program and then loads and runs random short programs, with
// row reads and noise items in between. Both sides of the handshake idle at
// random, with one long receiver stall and full drains mid-run and at the end.
// ============================================================================
`default_nettype none

module chip8_subset_instruction_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1200;
    localparam int CALM_FROM     = 1050;
    localparam int HOLD_AT       = 300;
    localparam int DRAIN_AT      = 700;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 12000;

    // opcodes that the core only steps over
    localparam logic [15:0] OP_RET   = 16'h00EE;
    localparam logic [3:0]  OPG_CALL = 4'h2;
    localparam logic [3:0]  OPG_MISC = 4'hF;

    typedef struct packed {
        logic [c8e_pkg::ADDR_W-1:0]      pc;
        logic [15:0]                     opcode;
        logic [c8e_pkg::ADDR_W-1:0]      index;
        logic                            status;
        logic [c8e_pkg::SCREEN_COLS-1:0] row;
    } t_exec_result;

    class t_exec_scoreboard;
        logic [7:0]                      prog_mem [c8e_pkg::MEM_BYTES];
        logic [7:0]                      vregs [c8e_pkg::NUM_VREGS];
        logic [c8e_pkg::ADDR_W-1:0]      index_reg;
        logic [c8e_pkg::ADDR_W-1:0]      pc_reg;
        logic [c8e_pkg::SCREEN_COLS-1:0] frame [c8e_pkg::SCREEN_ROWS];
        t_exec_result                    pending_results [$];
        int                              mismatches;

        function new();
            foreach (prog_mem[i]) prog_mem[i] = '0;
            foreach (vregs[i]) vregs[i] = '0;
            foreach (frame[i]) frame[i] = '0;
            index_reg  = '0;
            pc_reg     = c8e_pkg::PC_START;
            mismatches = 0;
        endfunction

        // executes one opcode on the model state, returns the unsupported flag
        function logic run_opcode(logic [15:0] op);
            logic [3:0]                 x;
            logic [3:0]                 y;
            logic [7:0]                 nn;
            logic [c8e_pkg::ADDR_W-1:0] next_pc;
            logic                       unsupported;
            logic [7:0]                 sprite;
            logic [c8e_pkg::ROW_W-1:0]  sy;
            logic [c8e_pkg::COL_W-1:0]  sx;
            int                         r;
            int                         c;
            x           = op[11:8];
            y           = op[7:4];
            nn          = op[7:0];
            next_pc     = pc_reg + 12'd2;
            unsupported = 1'b0;
            case (op[15:12])
                c8e_pkg::OPG_SYS: begin
                    if (op == c8e_pkg::OP_CLS) begin
                        foreach (frame[i]) frame[i] = '0;
                    end else begin
                        unsupported = 1'b1;
                    end
                end
                c8e_pkg::OPG_JP:  next_pc = op[11:0];
                c8e_pkg::OPG_SE: begin
                    if (vregs[x] == nn) next_pc = pc_reg + 12'd4;
                end
                c8e_pkg::OPG_LDV: vregs[x] = nn;
                c8e_pkg::OPG_ADD: vregs[x] = vregs[x] + nn;
                c8e_pkg::OPG_LDI: index_reg = op[11:0];
                c8e_pkg::OPG_DRW: begin
                    for (r = 0; r < op[3:0]; r++) begin
                        sprite = prog_mem[index_reg + 12'(r)];
                        sy     = vregs[y][c8e_pkg::ROW_W-1:0] + 5'(r);
                        for (c = 0; c < 8; c++) begin
                            sx = vregs[x][c8e_pkg::COL_W-1:0] + 6'(c);
                            if (sprite[7-c]) frame[sy][c8e_pkg::SCREEN_COLS-1-sx] ^= 1'b1;
                        end
                    end
                end
                default: unsupported = 1'b1;
            endcase
            pc_reg = next_pc;
            return unsupported;
        endfunction

        function void note_item(logic [1:0] m, logic [c8e_pkg::ADDR_W-1:0] a,
                                logic [7:0] d);
            t_exec_result r;
            logic [15:0]  op;
            r = '0;
            case (m)
                c8e_pkg::MODE_LOAD: begin
                    prog_mem[a] = d;
                    pc_reg      = c8e_pkg::PC_START;
                end
                c8e_pkg::MODE_EXEC: begin
                    op       = {prog_mem[pc_reg], prog_mem[pc_reg + 12'd1]};
                    r.opcode = op;
                    r.status = run_opcode(op);
                end
                c8e_pkg::MODE_READ: r.row = frame[a[c8e_pkg::ROW_W-1:0]];
                default: ;
            endcase
            r.pc    = pc_reg;
            r.index = index_reg;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_exec_result got);
            t_exec_result want;
            if (pending_results.size() == 0) begin
                $error("result item arrived with no item pending");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("program_counter", 64'(want.pc), 64'(got.pc));
            compare_field("opcode_run", 64'(want.opcode), 64'(got.opcode));
            compare_field("index_value", 64'(want.index), 64'(got.index));
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("screen_row", want.row, got.row);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    c8e_in_if  in_ch ();
    c8e_out_if out_ch ();

    chip8_subset_instruction_executor u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_exec_scoreboard board = new();

    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit long_hold = 1'b0;
    int n_sent    = 0;

    initial begin
        clk = 1'b0;
    end

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // accepted items and results, sampled with pre-edge values
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                board.note_item(in_ch.mode, in_ch.address, in_ch.data);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                board.check_result({out_ch.program_counter, out_ch.opcode_run,
                                    out_ch.index_value, out_ch.status, out_ch.screen_row});
        end
    end

    // receiver: ready runs, random stall bursts, one long hold on request
    initial begin
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                stalled = 0;
            else
                stalled++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_item(input logic [1:0] m, input logic [c8e_pkg::ADDR_W-1:0] a,
                             input logic [7:0] d);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.address <= a;
        in_ch.data    <= d;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        if (m != c8e_pkg::MODE_NOP) n_sent++;
    endtask

    // big-endian opcode into two memory bytes
    task automatic load_word(input logic [c8e_pkg::ADDR_W-1:0] a, input logic [15:0] op);
        send_item(c8e_pkg::MODE_LOAD, a, op[15:8]);
        send_item(c8e_pkg::MODE_LOAD, a + 12'd1, op[7:0]);
    endtask

    task automatic run_step();
        send_item(c8e_pkg::MODE_EXEC, 12'($urandom), 8'($urandom));
    endtask

    // wait for a clock edge before the first check, so the item accepted at the last edge is counted
    task automatic wait_drained();
        do @(posedge clk); while (board.outstanding() != 0);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_opcode();
        logic [3:0] x;
        logic [3:0] y;
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 12))
            0: return c8e_pkg::OP_CLS;
            1: return {c8e_pkg::OPG_JP,
                       c8e_pkg::PC_START + 12'($urandom_range(0, 9) * 2)};
            2: return {c8e_pkg::OPG_JP, 12'($urandom)};
            3, 4: return {c8e_pkg::OPG_SE, x, random_byte()};
            5: return {c8e_pkg::OPG_LDV, x, random_byte()};
            6: return {c8e_pkg::OPG_ADD, x, random_byte()};
            7: begin
                // point the index into the program now and then, so sprites have bits
                if ($urandom_range(0, 1) == 0)
                    return {c8e_pkg::OPG_LDI,
                            c8e_pkg::PC_START + 12'($urandom_range(0, 20))};
                return {c8e_pkg::OPG_LDI, 12'($urandom)};
            end
            8, 9: return {c8e_pkg::OPG_DRW, x, y, 4'($urandom_range(0, 15))};
            10: begin
                case ($urandom_range(0, 2))
                    0: return OP_RET;
                    1: return {OPG_CALL, 12'($urandom)};
                    default: return {OPG_MISC, 12'($urandom)};
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int  prog_len;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= c8e_pkg::MODE_LOAD;
        in_ch.address <= '0;
        in_ch.data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fresh state, ignored mode, then a program touching every opcode
        send_item(c8e_pkg::MODE_READ, 12'hFFF, 8'h00);
        send_item(c8e_pkg::MODE_NOP, 12'hFFF, 8'hFF);
        run_step();
        send_item(c8e_pkg::MODE_LOAD, 12'hFFF, 8'hFF);
        send_item(c8e_pkg::MODE_LOAD, 12'h000, 8'hA5);
        load_word(12'h200, {c8e_pkg::OPG_LDI, 12'hFFF});
        load_word(12'h202, {c8e_pkg::OPG_LDV, 4'h0, 8'hFF});
        load_word(12'h204, {c8e_pkg::OPG_DRW, 4'h0, 4'h0, 4'hF});
        load_word(12'h206, {c8e_pkg::OPG_ADD, 4'h0, 8'h02});
        load_word(12'h208, {c8e_pkg::OPG_SE, 4'h0, 8'h01});
        load_word(12'h20C, {c8e_pkg::OPG_DRW, 4'h0, 4'h0, 4'h0});
        load_word(12'h20E, c8e_pkg::OP_CLS);
        load_word(12'h210, {c8e_pkg::OPG_JP, 12'hFFF});
        // sprite rows wrap in memory and on both screen axes
        repeat (3) run_step();
        send_item(c8e_pkg::MODE_READ, 12'h03F, 8'h00);
        send_item(c8e_pkg::MODE_READ, 12'hFE0, 8'hFF);
        // add wraps to one, skip taken, then an empty draw
        repeat (3) run_step();
        send_item(c8e_pkg::MODE_READ, 12'h001, 8'h00);
        run_step();
        send_item(c8e_pkg::MODE_READ, 12'h03F, 8'h00);
        // jump to the top byte: fetch wraps into address zero, pc wraps past it
        repeat (3) run_step();

        while (n_sent < ITEM_TARGET) begin
            if (!hold_done && n_sent >= HOLD_AT) begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && n_sent >= DRAIN_AT) begin
                in_ch.valid <= 1'b0;
                wait_drained();
                drain_done = 1'b1;
            end
            if (n_sent >= CALM_FROM) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            if ($urandom_range(0, 9) < 8) begin
                prog_len = $urandom_range(2, 10);
                for (int k = 0; k < prog_len; k++)
                    load_word(c8e_pkg::PC_START + 12'(2 * k), random_opcode());
                repeat ($urandom_range(0, 3))
                    send_item(c8e_pkg::MODE_LOAD, 12'($urandom), 8'($urandom));
                repeat (prog_len + $urandom_range(0, 4)) run_step();
                repeat ($urandom_range(1, 3))
                    send_item(c8e_pkg::MODE_READ, 12'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom), 12'($urandom), 8'($urandom));
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.outstanding() != 0) begin
            $error("%0d result items never arrived", board.outstanding());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/c8e_pkg.sv
rtl/c8e_if.sv
rtl/c8e_pmem.sv
rtl/c8e_fbuf.sv
rtl/c8e_vreg.sv
rtl/chip8_subset_instruction_executor.sv
rtl/c8e_checker.sv
tb/chip8_subset_instruction_executor_tb.sv
